// ----- rtl/core/bcle_pkg.sv -----
// ----------------------------------------------------------------------------
// bcle_pkg: shared types and constants for the C literal escaper
// Character and run types, run length limits and register indexes.
// ----------------------------------------------------------------------------
package bcle_pkg;

  localparam int unsigned MaxRun     = 8;
  localparam int unsigned RunLenW    = $clog2(MaxRun + 1);
  localparam int unsigned LimitW     = 12;
  localparam int unsigned CountW     = LimitW + 1;
  localparam int unsigned CfgIndexW  = 1;

  localparam logic [LimitW-1:0] LineLimitReset = 12'd120;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] CfgAlwaysEscape = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgLineLimit    = 1'd1;

  typedef logic [7:0] char_t;

  // One fully expanded run: characters in emit order, element 0 first
  typedef struct packed {
    char_t [MaxRun-1:0] chars;
    logic  [RunLenW-1:0] len;
  } run_t;

endpackage

// ----- rtl/core/byte_to_c_literal_escaper_top.sv -----
// ----------------------------------------------------------------------------
// byte_to_c_literal_escaper_top: C string literal escaper with line wrap
// An accepted input beat passes through the input register and then the output
// shift register before its first output beat. The output gives one character
// per cycle while out_ready is high; a byte's run holds 1, 2 or 4 characters,
// plus 4 when the line breaks. A held byte moves on once the run ahead of it is
// gone, or is on its last character and out_ready is high.
// Reset (rst, synchronous): pipeline empty, line counter zero,
// always_escape 0, line_limit 120.
// ----------------------------------------------------------------------------
module byte_to_c_literal_escaper_top
  import bcle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input byte channel
  input  logic                 data_valid,
  output logic                 data_ready,
  input  logic [7:0]           data_byte,
  // escaped character channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 run_end,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [LimitW-1:0]    cfg_data
);

  // Configuration registers
  logic              always_escape;
  logic [LimitW-1:0] line_limit;

  // Input register: one byte waiting for the encoder
  logic              in_full;
  char_t             in_byte;

  // Line character counter and encoder results
  logic [CountW-1:0] line_count;
  logic [CountW-1:0] line_count_next;
  run_t              run;
  logic              load_ready;
  logic              encode_fire;

  // Configuration is always taken; writes to unknown indexes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      always_escape <= 1'b0;
      line_limit    <= LineLimitReset;
    end else if (cfg_valid) begin
      if (cfg_index == CfgAlwaysEscape) begin
        always_escape <= cfg_data[0];
      end else if (cfg_index == CfgLineLimit) begin
        line_limit <= cfg_data;
      end
    end
  end

  // The input register frees up in the same cycle its byte moves on,
  // so a fresh beat can follow back to back.
  assign encode_fire = in_full && load_ready;
  assign data_ready  = !in_full || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_valid && data_ready) begin
      in_full <= 1'b1;
    end else if (encode_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  // Expand the held byte into its full run, break included
  bcle_encoder u_encoder (
    .byte_in         (in_byte),
    .always_escape   (always_escape),
    .line_limit      (line_limit),
    .line_count      (line_count),
    .run             (run),
    .line_count_next (line_count_next)
  );

  // Advance the counter once per encoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (encode_fire) begin
      line_count <= line_count_next;
    end
  end

  // Emit the run one character per beat; run_end marks its last one
  bcle_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_full),
    .load_ready (load_ready),
    .run        (run),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .run_end    (run_end)
  );

  // Every encoded run has between one and eight characters
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    encode_fire |-> (run.len != '0 && run.len <= RunLenW'(MaxRun)))
    else $error("encoded run length out of range");

  // The counter clears on a break, so it never runs far past the limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= CountW'(4098))
    else $error("line counter overshoot");

  // A run handed to the serializer shows on the output the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    encode_fire |=> out_valid)
    else $error("loaded run not presented");

endmodule

// ----- rtl/core/bcle_encoder.sv -----
// ----------------------------------------------------------------------------
// bcle_encoder: byte to escaped run
// Classifies one byte, builds its escape characters and appends the line
// break when the line counter plus the escape length reaches the limit.
// ----------------------------------------------------------------------------
module bcle_encoder
  import bcle_pkg::*;
(
  input  char_t              byte_in,
  input  logic               always_escape,
  input  logic [LimitW-1:0]  line_limit,
  input  logic [CountW-1:0]  line_count,
  output run_t               run,
  output logic [CountW-1:0]  line_count_next
);

  typedef enum logic [1:0] {
    EscPlain,
    EscPair,
    EscOctal
  } esc_t;

  esc_t              cls;
  char_t             pair_char;
  logic [2:0]        base_len;
  logic [CountW-1:0] sum;
  logic              wrap;
  char_t             oct2;
  char_t             oct1;
  char_t             oct0;

  // Pick the escape class of the byte
  always_comb begin
    pair_char = "\\";
    if (always_escape) begin
      cls = EscOctal;
    end else if (byte_in >= 8'd32 && byte_in <= 8'd126 && byte_in != "\"" &&
                 byte_in != "\\" && byte_in != "?" && byte_in != ":" &&
                 byte_in != "%") begin
      cls = EscPlain;
    end else if (byte_in == 8'h0d) begin
      cls = EscPair;
      pair_char = "r";
    end else if (byte_in == 8'h0a) begin
      cls = EscPair;
      pair_char = "n";
    end else if (byte_in == 8'h09) begin
      cls = EscPair;
      pair_char = "t";
    end else if (byte_in == "\"") begin
      cls = EscPair;
      pair_char = "\"";
    end else if (byte_in == "\\") begin
      cls = EscPair;
      pair_char = "\\";
    end else begin
      cls = EscOctal;
    end
  end

  assign oct2 = 8'h30 + {6'd0, byte_in[7:6]};
  assign oct1 = 8'h30 + {5'd0, byte_in[5:3]};
  assign oct0 = 8'h30 + {5'd0, byte_in[2:0]};

  always_comb begin
    unique case (cls)
      EscPlain: base_len = 3'd1;
      EscPair:  base_len = 3'd2;
      EscOctal: base_len = 3'd4;
      default:  base_len = 3'd4;
    endcase
  end

  assign sum             = line_count + CountW'(base_len);
  assign wrap            = sum >= {1'b0, line_limit};
  assign line_count_next = wrap ? '0 : sum;

  // Lay out the run, break characters right after the escape
  always_comb begin
    run.chars = '0;
    unique case (cls)
      EscPlain: begin
        run.chars[0] = byte_in;
        if (wrap) begin
          run.chars[1] = "\"";
          run.chars[2] = 8'h0a;
          run.chars[3] = 8'h09;
          run.chars[4] = "\"";
        end
      end
      EscPair: begin
        run.chars[0] = "\\";
        run.chars[1] = pair_char;
        if (wrap) begin
          run.chars[2] = "\"";
          run.chars[3] = 8'h0a;
          run.chars[4] = 8'h09;
          run.chars[5] = "\"";
        end
      end
      default: begin
        run.chars[0] = "\\";
        run.chars[1] = oct2;
        run.chars[2] = oct1;
        run.chars[3] = oct0;
        if (wrap) begin
          run.chars[4] = "\"";
          run.chars[5] = 8'h0a;
          run.chars[6] = 8'h09;
          run.chars[7] = "\"";
        end
      end
    endcase
    run.len = RunLenW'(base_len) + (wrap ? RunLenW'(4) : RunLenW'(0));
  end

endmodule

// ----- rtl/core/bcle_serializer.sv -----
// ----------------------------------------------------------------------------
// bcle_serializer: run to character stream
// Holds one run in a shift register and emits one character per beat.
// ----------------------------------------------------------------------------
module bcle_serializer
  import bcle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load_valid,
  output logic  load_ready,
  input  run_t  run,
  output logic  out_valid,
  input  logic  out_ready,
  output char_t out_char,
  output logic  run_end
);

  char_t [MaxRun-1:0] chars;
  logic [RunLenW-1:0] cnt;
  logic               pop;

  assign out_valid  = cnt != '0;
  assign pop        = out_valid && out_ready;
  assign load_ready = (cnt == '0) || (cnt == RunLenW'(1) && out_ready);
  assign out_char   = chars[0];
  assign run_end    = cnt == RunLenW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_valid && load_ready) begin
      cnt <= run.len;
    end else if (pop) begin
      cnt <= cnt - RunLenW'(1);
    end
  end

  // Load or advance the shift line; payload needs no reset
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      chars <= run.chars;
    end else if (pop) begin
      chars <= {8'h00, chars[MaxRun-1:1]};
    end
  end

endmodule
